// ===== rtl/core/assert_macros.svh =====
// shared assertion macros for the fan control checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define FMCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// assertion that only looks at a presented result beat
`define FMCC_ASSERT_OUT(lbl, prop, msg) \
  `FMCC_ASSERT(lbl, out_valid_o |-> (prop), msg)

`endif

// ===== rtl/core/fmcc_pkg.sv =====
`default_nettype none
package fmcc_pkg;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_STD    = 2'd1,
    MODE_SLEEP  = 2'd2,
    MODE_THERMO = 2'd3
  } fmcc_mode_e;

  typedef enum logic [1:0] {
    CD_OFF     = 2'd0,
    CD_SET_SEC = 2'd1,
    CD_SET_MIN = 2'd2,
    CD_RUN     = 2'd3
  } fmcc_cd_e;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [4:0] KEY_MODE  = 5'd1;
  localparam logic [4:0] KEY_SWING = 5'd2;
  localparam logic [4:0] KEY_SPEED = 5'd3;
  localparam logic [4:0] KEY_TIMER = 5'd4;
  localparam logic [4:0] KEY_SET1  = 5'd5;
  localparam logic [4:0] KEY_SET5  = 5'd21;
  localparam logic [4:0] KEY_DISP  = 5'd6;

  localparam logic [5:0] SEC_MAX = 6'd59;
  localparam logic [6:0] MIN_MAX = 7'd99;

  typedef struct packed {
    fmcc_mode_e         mode;
    logic [1:0]         swing;
    logic [1:0]         speed;
    fmcc_cd_e           cd_mode;
    logic [6:0]         minutes;
    logic [5:0]         seconds;
    logic               disp;
    logic signed [11:0] temp;
    logic [6:0]         duty;
  } fmcc_state_t;

  localparam fmcc_state_t STATE_RST = '{
    mode:    MODE_OFF,
    swing:   2'd0,
    speed:   2'd1,
    cd_mode: CD_OFF,
    minutes: 7'd0,
    seconds: 6'd0,
    disp:    1'b0,
    temp:    12'sd0,
    duty:    7'd0
  };

  typedef struct packed {
    fmcc_state_t st;
    logic [6:0]  drive_duty;
    logic        duty_valid;
    logic        expired;
  } fmcc_res_t;

  function automatic fmcc_mode_e fmcc_next_mode(input fmcc_mode_e m);
    fmcc_mode_e r;
    case (m)
      MODE_OFF:    r = MODE_STD;
      MODE_STD:    r = MODE_SLEEP;
      MODE_SLEEP:  r = MODE_THERMO;
      MODE_THERMO: r = MODE_OFF;
      default:     r = MODE_OFF;
    endcase
    return r;
  endfunction

  function automatic fmcc_cd_e fmcc_next_cd(input fmcc_cd_e c);
    fmcc_cd_e r;
    case (c)
      CD_OFF:     r = CD_SET_SEC;
      CD_SET_SEC: r = CD_SET_MIN;
      CD_SET_MIN: r = CD_RUN;
      CD_RUN:     r = CD_OFF;
      default:    r = CD_OFF;
    endcase
    return r;
  endfunction

  // speed * 40 - 30 for speeds 1 to 3; speed 0 gives 98
  function automatic logic [6:0] fmcc_drive_duty(input logic [1:0] speed);
    logic [6:0] r;
    case (speed)
      2'd1:    r = 7'd10;
      2'd2:    r = 7'd50;
      2'd3:    r = 7'd90;
      default: r = 7'd98;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fmcc_next.sv =====
`default_nettype none
module fmcc_next (
  input  logic                      op_i,
  input  logic [4:0]                key_i,
  input  logic signed [11:0]        temp_i,
  input  logic [6:0]                duty_i,
  input  fmcc_pkg::fmcc_state_t     st_q_i,
  output fmcc_pkg::fmcc_state_t     st_d_o,
  output fmcc_pkg::fmcc_res_t       res_o
);
  import fmcc_pkg::*;

  fmcc_state_t s;
  logic        expired;
  logic [6:0]  sec_sum;

  always_comb begin
    s       = st_q_i;
    expired = 1'b0;
    sec_sum = {1'b0, st_q_i.seconds} + ((key_i == KEY_SET1) ? 7'd1 : 7'd5);
    if (op_i == OP_KEY) begin
      if (key_i == KEY_MODE) begin
        s.mode = fmcc_next_mode(st_q_i.mode);
        if (s.mode == MODE_OFF) begin
          s.swing   = 2'd0;
          s.speed   = 2'd1;
          s.cd_mode = CD_OFF;
          s.minutes = 7'd0;
          s.seconds = 6'd0;
        end else if (s.mode == MODE_THERMO) begin
          s.temp = temp_i;
          s.duty = duty_i;
        end
      end else if (key_i == KEY_SWING && st_q_i.mode != MODE_OFF) begin
        s.swing = (st_q_i.swing >= 2'd2) ? 2'd0 : st_q_i.swing + 2'd1;
      end else if (key_i == KEY_SPEED && st_q_i.mode == MODE_STD) begin
        s.speed = (st_q_i.speed >= 2'd3) ? 2'd1 : st_q_i.speed + 2'd1;
      end else if (key_i == KEY_TIMER && st_q_i.mode != MODE_OFF) begin
        s.cd_mode = fmcc_next_cd(st_q_i.cd_mode);
        if (s.cd_mode == CD_OFF) begin
          s.minutes = 7'd0;
          s.seconds = 6'd0;
        end
      end else if ((key_i == KEY_SET1 || key_i == KEY_SET5) && st_q_i.mode != MODE_OFF) begin
        if (st_q_i.cd_mode == CD_SET_SEC) begin
          // wrap at one minute
          s.seconds = (sec_sum > {1'b0, SEC_MAX}) ? 6'(sec_sum - 7'd60) : sec_sum[5:0];
        end else if (st_q_i.cd_mode == CD_SET_MIN) begin
          s.minutes = (st_q_i.minutes >= MIN_MAX) ? 7'd0 : st_q_i.minutes + 7'd1;
        end
      end else if (key_i == KEY_DISP) begin
        s.disp = ~st_q_i.disp;
      end
    end else if (st_q_i.cd_mode == CD_RUN) begin
      if (st_q_i.seconds == 6'd0) begin
        if (st_q_i.minutes == 7'd0) begin
          // countdown done, shut everything off
          s.mode    = MODE_OFF;
          s.swing   = 2'd0;
          s.speed   = 2'd1;
          s.cd_mode = CD_OFF;
          s.disp    = 1'b0;
          expired   = 1'b1;
        end else begin
          s.minutes = st_q_i.minutes - 7'd1;
          s.seconds = SEC_MAX;
        end
      end else begin
        s.seconds = st_q_i.seconds - 6'd1;
      end
    end
  end

  always_comb begin
    st_d_o           = s;
    res_o.st         = s;
    res_o.expired    = expired;
    res_o.duty_valid = (s.mode == MODE_OFF) || (s.mode == MODE_STD);
    res_o.drive_duty = (s.mode == MODE_STD) ? fmcc_drive_duty(s.speed) : 7'd0;
  end

endmodule
`default_nettype wire

// ===== rtl/core/fan_mode_and_countdown_control_core.sv =====
// Fan mode and countdown controller. Each input beat is a key press or a one-second
// tick; each one yields exactly one result beat carrying the fan state after the
// update, plus the standard-mode drive duty and a flag for a countdown that just ran
// out. Throughput is one beat per cycle while the result side does not stall. Each
// beat goes through the input register and then the result register; the state update
// is combinational logic between them, which also feeds the state registers.
// The input side only stalls while the result register is full and stalled.
`default_nettype none
module fan_mode_and_countdown_control_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [4:0]         key_code_i,
  input  logic signed [11:0] current_temp_i,
  input  logic [6:0]         current_duty_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         fan_mode_out_o,
  output logic [1:0]         swing_speed_o,
  output logic [1:0]         speed_level_o,
  output logic [1:0]         countdown_mode_o,
  output logic [6:0]         count_minutes_o,
  output logic [5:0]         count_seconds_o,
  output logic               show_status_o,
  output logic signed [11:0] captured_temp_o,
  output logic [6:0]         captured_duty_o,
  output logic [6:0]         drive_duty_o,
  output logic               duty_valid_o,
  output logic               timer_expired_o
);
  import fmcc_pkg::*;

  logic               in_vld_q;
  logic               op_q;
  logic [4:0]         key_q;
  logic signed [11:0] temp_q;
  logic [6:0]         duty_q;
  fmcc_state_t        st_q, st_d;
  fmcc_res_t          res_d, res_q;
  logic               out_vld_q;
  logic               load_in, advance;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign load_in    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= STATE_RST;
    end else begin
      if (load_in) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      op_q   <= operation_i;
      key_q  <= key_code_i;
      temp_q <= current_temp_i;
      duty_q <= current_duty_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  fmcc_next u_next (
    .op_i   (op_q),
    .key_i  (key_q),
    .temp_i (temp_q),
    .duty_i (duty_q),
    .st_q_i (st_q),
    .st_d_o (st_d),
    .res_o  (res_d)
  );

  assign out_valid_o      = out_vld_q;
  assign fan_mode_out_o   = res_q.st.mode;
  assign swing_speed_o    = res_q.st.swing;
  assign speed_level_o    = res_q.st.speed;
  assign countdown_mode_o = res_q.st.cd_mode;
  assign count_minutes_o  = res_q.st.minutes;
  assign count_seconds_o  = res_q.st.seconds;
  assign show_status_o    = res_q.st.disp;
  assign captured_temp_o  = res_q.st.temp;
  assign captured_duty_o  = res_q.st.duty;
  assign drive_duty_o     = res_q.drive_duty;
  assign duty_valid_o     = res_q.duty_valid;
  assign timer_expired_o  = res_q.expired;

endmodule
`default_nettype wire

// ===== rtl/core/fmcc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module fmcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] fan_mode_out_o,
  input logic [1:0] swing_speed_o,
  input logic [1:0] speed_level_o,
  input logic [1:0] countdown_mode_o,
  input logic [6:0] count_minutes_o,
  input logic [5:0] count_seconds_o,
  input logic [6:0] drive_duty_o,
  input logic       timer_expired_o
);
  import fmcc_pkg::*;

  // an expiry beat shows the fully cleared state
  `FMCC_ASSERT_OUT(a_expire_clear, !timer_expired_o || (fan_mode_out_o == MODE_OFF && countdown_mode_o == CD_OFF && count_minutes_o == 7'd0 && count_seconds_o == 6'd0 && swing_speed_o == 2'd0), "expiry without cleared state")
  // only standard mode drives the fan
  `FMCC_ASSERT_OUT(a_drive_std, drive_duty_o == 7'd0 || fan_mode_out_o == MODE_STD, "drive duty outside standard mode")
  // counters and levels stay in their ranges
  `FMCC_ASSERT_OUT(a_ranges, count_seconds_o <= SEC_MAX && count_minutes_o <= MIN_MAX && speed_level_o != 2'd0 && swing_speed_o != 2'd3, "state out of range")
  // a stalled result beat holds
  `FMCC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(count_seconds_o) && $stable(fan_mode_out_o), "stalled result changed")

endmodule

bind fan_mode_and_countdown_control_core fmcc_checker u_fmcc_checker (.*);
`default_nettype wire
